FILE: hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-224/256 package
// Shared types, round constants, initial hash values and a rotate helper for the hash unit.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_ABSORB,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            unique case (t)
                6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hB5C0FBCF; 6'd3: k = 32'hE9B5DBA5;
                6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
                6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5;
                6'd8: k = 32'hD807AA98; 6'd9: k = 32'h12835B01;
                6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
                6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
                6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
                6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
                6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
                6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
                6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
                6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
                6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
                6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
                6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
                6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
                6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
                6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
                6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
                6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
                6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
                6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
                6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
                6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
                6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
                6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
                6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
                6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
                6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
                6'd62: k = 32'hBEF9A3F7; default: k = 32'hC67178F2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_value(input logic m224, input logic [2:0] i);
        logic [31:0] v;
        begin
            unique case ({m224, i})
                4'h0: v = 32'h6A09E667; 4'h1: v = 32'hBB67AE85;
                4'h2: v = 32'h3C6EF372; 4'h3: v = 32'hA54FF53A;
                4'h4: v = 32'h510E527F; 4'h5: v = 32'h9B05688C;
                4'h6: v = 32'h1F83D9AB; 4'h7: v = 32'h5BE0CD19;
                4'h8: v = 32'hC1059ED8; 4'h9: v = 32'h367CD507;
                4'hA: v = 32'h3070DD17; 4'hB: v = 32'hF70E5939;
                4'hC: v = 32'hFFC00B31; 4'hD: v = 32'h68581511;
                4'hE: v = 32'h64F98FA7; default: v = 32'hBEFA4FA4;
            endcase
            return v;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hdl/sha_block_ram.sv
// ----------------------------------------------------------------------------
// SHA block buffer
// Word-wide message block memory with byte write enables, one read port.
// ----------------------------------------------------------------------------
module sha_block_ram
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [3:0]  wbe,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr,
    output logic [31:0] rdata
);
    logic [31:0] mem [16];

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (we && wbe[b])
            begin
                mem[waddr][b*8 +: 8] <= wdata[b*8 +: 8];
            end
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/sha_sched_ram.sv
// ----------------------------------------------------------------------------
// SHA schedule window
// Sixteen-word message schedule memory with two registered read ports.
// ----------------------------------------------------------------------------
module sha_sched_ram
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr_a,
    input  logic [3:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b
);
    logic [31:0] mem [16];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

FILE: hdl/sha224_sha256_hash_unit.sv
// ----------------------------------------------------------------------------
// SHA-224/SHA-256 hash unit
// Byte-serial message hasher with block buffer and iterative compression.
// ----------------------------------------------------------------------------
// Absorb: one byte per cycle while input is not stalled; the byte that completes
//   a block stalls input through the schedule load, the 64 rounds and the fold.
// Finish with n bytes buffered: padding and one compression for n < 56, else
//   padding, compression, padding and compression; then 7 or 8 words at one
//   per cycle while out_stall is low, input stalled until the last word is taken.
// Reset: SHA-224 mode, SHA-224 initial values, byte count zero.
module sha224_sha256_hash_unit
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  message_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    state_t      state_reg, state_next;
    logic        mode_reg;
    logic [63:0] total_reg, total_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [6:0]  t_reg, t_next;
    logic        fin_reg, fin_next;
    logic        two_reg, two_next;
    logic [5:0]  pad_reg, pad_next;
    logic [3:0]  oi_reg, oi_next;
    logic        ov_reg;

    logic        bw;
    logic [3:0]  bwa, bra;
    logic [3:0]  bbe;
    logic [31:0] bwd, brd;
    logic        sw;
    logic [3:0]  swa, sra, srb;
    logic [31:0] swd, sda, sdb;

    logic        acc, blk_full;
    logic [5:0]  used;
    logic [31:0] w15_reg, w2_reg, wcur;
    logic [31:0] t1, t2, s0, s1;
    logic        rnd_go, new_w;
    logic [5:0]  rt;
    logic [31:0] lenw;
    logic [7:0]  pbyte;

    sha_block_ram u_blk (
        .clk(clk), .we(bw), .waddr(bwa), .wbe(bbe), .wdata(bwd),
        .raddr(bra), .rdata(brd)
    );
    sha_sched_ram u_sch (
        .clk(clk), .we(sw), .waddr(swa), .wdata(swd),
        .raddr_a(sra), .raddr_b(srb), .rdata_a(sda), .rdata_b(sdb)
    );

    assign used     = total_reg[5:0];
    assign acc      = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_ABSORB);
    assign blk_full = (used == 6'd63);

    // Run round rt on odd t_reg; fetch its window words on the odd and even t_reg before it.
    assign rt     = t_reg[6:1] - 6'd1;
    assign rnd_go = (state_reg == ST_ROUND) && t_reg[0];
    assign new_w  = rt >= 6'd16;
    assign s0 = rotr(w15_reg, 7) ^ rotr(w15_reg, 18) ^ (w15_reg >> 3);
    assign s1 = rotr(w2_reg, 17) ^ rotr(w2_reg, 19) ^ (w2_reg >> 10);
    assign wcur = new_w ? (s1 + sdb + s0 + sda) : sda;
    assign t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rt) + wcur;
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        lenw = '0;
        unique case (pad_reg[2:0])
            3'd0:    lenw = total_reg[60:29];
            default: lenw = {total_reg[28:0], 3'b000};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        t_next     = t_reg;
        fin_next   = fin_reg;
        two_next   = two_reg;
        pad_next   = pad_reg;
        oi_next    = oi_reg;
        bw  = 1'b0;
        bwa = used[5:2];
        bbe = 4'b1000 >> used[1:0];
        bwd = {4{message_byte}};
        bra = '0;
        sw  = 1'b0;
        swa = '0;
        swd = '0;
        sra = '0;
        srb = '0;
        pbyte = 8'h00;
        unique case (state_reg)
            ST_ABSORB:
            begin
                if (acc)
                begin
                    if (cmd == CMD_ABSORB)
                    begin
                        bw = 1'b1;
                        total_next = total_reg + 64'd1;
                        if (blk_full)
                        begin
                            fin_next   = 1'b0;
                            state_next = ST_LOAD;
                            t_next     = '0;
                        end
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        two_next   = (used >= 6'd56);
                        pad_next   = used;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // Byte-wise padding over the buffer, then length words in the final block.
                pbyte = (pad_reg == used) ? 8'h80 : 8'h00;
                bw  = 1'b1;
                bwa = pad_reg[5:2];
                bbe = 4'b1000 >> pad_reg[1:0];
                bwd = {4{pbyte}};
                if (!two_reg && pad_reg >= 6'd56)
                begin
                    bbe = 4'b1111;
                    bwd = lenw;
                    pad_next = pad_reg + 6'd4;
                    if (pad_reg == 6'd60)
                    begin
                        state_next = ST_LOAD;
                        t_next = '0;
                    end
                end
                else
                begin
                    pad_next = pad_reg + 6'd1;
                    if (pad_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        t_next = '0;
                    end
                end
            end
            ST_LOAD:
            begin
                // Copy block words into the schedule window.
                bra = t_reg[3:0];
                sw  = (t_reg != 7'd0);
                swa = t_reg[3:0] - 4'd1;
                swd = brd;
                t_next = t_reg + 7'd1;
                if (t_reg == 7'd16)
                begin
                    state_next = ST_ROUND;
                    t_next = 7'd2;
                end
            end
            ST_ROUND:
            begin
                t_next = t_reg + 7'd1;
                if (t_reg[0])
                begin
                    sra = rt[3:0] + 4'd2;
                    srb = rt[3:0] + 4'd15;
                end
                else
                begin
                    sra = rt[3:0];
                    srb = rt[3:0] + 4'd9;
                end
                if (rnd_go)
                begin
                    sw  = new_w;
                    swa = rt[3:0];
                    swd = wcur;
                    if (rt == 6'd63)
                    begin
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_FOLD:
            begin
                if (fin_reg && two_reg)
                begin
                    two_next   = 1'b0;
                    pad_next   = 6'd0;
                    state_next = ST_PAD;
                end
                else if (fin_reg)
                begin
                    oi_next    = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_ABSORB;
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    if (oi_reg == (mode_reg ? 4'd7 : 4'd8))
                    begin
                        state_next = ST_ABSORB;
                        total_next = '0;
                    end
                    else
                    begin
                        oi_next = oi_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase
        if (cfg_we)
        begin
            total_next = '0;
        end
    end

    // Hold w[r-15] and w[r-2] fetched on the odd cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROUND && !t_reg[0])
        begin
            w15_reg <= sda;
            w2_reg  <= sdb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ABSORB;
            mode_reg    <= 1'b1;
            total_reg   <= '0;
            t_reg       <= '0;
            fin_reg     <= 1'b0;
            two_reg     <= 1'b0;
            pad_reg     <= '0;
            oi_reg      <= '0;
            ov_reg      <= 1'b0;
            digest_word <= '0;
            word_index  <= '0;
            last_word   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_value(1'b1, i[2:0]);
                v_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            t_reg     <= t_next;
            fin_reg   <= fin_next;
            two_reg   <= two_next;
            pad_reg   <= pad_next;
            oi_reg    <= oi_next;
            if (state_reg == ST_EMIT && (!ov_reg || !out_stall))
            begin
                ov_reg      <= (oi_reg != (mode_reg ? 4'd7 : 4'd8));
                digest_word <= h_reg[oi_reg[2:0]];
                word_index  <= oi_reg[2:0];
                last_word   <= (oi_reg == (mode_reg ? 4'd6 : 4'd7));
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (state_reg == ST_LOAD && t_reg == 7'd0)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            if (rnd_go)
            begin
                for (int i = 7; i > 0; i--)
                begin
                    if (i != 4)
                    begin
                        v_reg[i] <= v_reg[i-1];
                    end
                end
                v_reg[4] <= v_reg[3] + t1;
                v_reg[0] <= t1 + t2;
            end
            if (state_reg == ST_FOLD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= init_value(cfg_wdata, i[2:0]);
                end
            end
            else if (state_reg == ST_EMIT && state_next == ST_ABSORB)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= init_value(mode_reg, i[2:0]);
                end
            end
        end
    end

    assign out_valid = ov_reg;

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ABSORB) |-> in_stall) else $error("input not stalled");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(digest_word)) else $error("output moved");
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_word) |-> (word_index == 3'd6 || word_index == 3'd7))
        else $error("bad last index");
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-224/SHA-256 hash unit testbench
// Feeds byte messages and finish requests under random gaps and output
// stalls, computes the digest in a local hasher and checks every word.
// ----------------------------------------------------------------------------
module testbench;
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    class digest_scoreboard;
        logic [31:0]  chain[8];
        logic [7:0]   block_buf[64];
        logic [63:0]  byte_count;
        logic         sel_224;
        digest_item_t pending[$];
        int           errors;

        function new();
            errors = 0;
            sel_224 = 1'b1;
            restart();
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void restart();
            logic [31:0] iv256[8];
            logic [31:0] iv224[8];
            iv256 = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
            iv224 = '{32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
                      32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};
            for (int i = 0; i < 8; i++)
                chain[i] = sel_224 ? iv224[i] : iv256[i];
            byte_count = '0;
        endfunction

        function void set_mode(logic m);
            sel_224 = m;
            restart();
        endfunction

        function void compress();
            logic [31:0] kt[64];
            logic [31:0] w[64];
            logic [31:0] v[8];
            logic [31:0] t1, t2, s0, s1;
            kt = '{
                32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
                32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
                32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
                32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
                32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
                32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
                32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
                32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
                32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
                32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
                32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
                32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
                32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
                32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
                32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
                32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
            for (int t = 0; t < 16; t++)
                w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2],
                        block_buf[4*t+3]};
            for (int t = 16; t < 64; t++) begin
                s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
            for (int j = 0; j < 8; j++)
                v[j] = chain[j];
            for (int t = 0; t < 64; t++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kt[t] + w[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                for (int j = 7; j > 0; j--)
                    v[j] = v[j-1];
                v[4] = v[4] + t1;
                v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++)
                chain[j] = chain[j] + v[j];
        endfunction

        function void note_request(logic c, logic [7:0] b);
            int pos;
            int nwords;
            logic [63:0] bits;
            digest_item_t d;
            pos = byte_count[5:0];
            if (c == CMD_ABSORB) begin
                block_buf[pos] = b;
                byte_count = byte_count + 1;
                if (pos == 63)
                    compress();
                return;
            end
            block_buf[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                for (int i = pos; i < 64; i++)
                    block_buf[i] = 8'h00;
                compress();
                pos = 0;
            end
            for (int i = pos; i < 56; i++)
                block_buf[i] = 8'h00;
            bits = byte_count << 3;
            for (int j = 0; j < 8; j++)
                block_buf[56+j] = bits[63-8*j -: 8];
            compress();
            nwords = sel_224 ? 7 : 8;
            for (int j = 0; j < nwords; j++) begin
                d.word = chain[j];
                d.index = j[2:0];
                d.last = (j == nwords - 1);
                pending.push_back(d);
            end
            restart();
        endfunction

        function void check_word(logic [31:0] w, logic [2:0] idx, logic lst);
            digest_item_t e;
            if (pending.size() == 0) begin
                $error("unexpected digest word %h", w);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w !== e.word) begin
                $error("digest_word expected %h actual %h", e.word, w);
                errors++;
            end
            if (idx !== e.index) begin
                $error("word_index expected %0d actual %0d", e.index, idx);
                errors++;
            end
            if (lst !== e.last) begin
                $error("last_word expected %0d actual %0d", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [7:0]  message_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        stall_on;

    digest_scoreboard sb;

    sha224_sha256_hash_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .message_byte (message_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 200);
        return $urandom_range(1, 4);
    endfunction

    task automatic send_request(logic c, logic [7:0] b);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        message_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(c, b);
    endtask

    task automatic send_message(int len, bit rnd);
        for (int i = 0; i < len; i++)
            send_request(CMD_ABSORB, rnd ? 8'($urandom_range(0, 255)) : 8'(i));
        send_request(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        sb.set_mode(m);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        stall_on = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                stall_on = ~stall_on;
            if ($urandom_range(0, 40) == 0)
                out_stall <= 1'b1;
            else
                out_stall <= stall_on && ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(digest_word, word_index, last_word);
    end

    initial
    begin
        int len;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_ABSORB;
        message_byte = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, extreme bytes, then a discarded partial message
        send_message(0, 0);
        send_request(CMD_ABSORB, 8'h00);
        send_request(CMD_ABSORB, 8'hFF);
        send_request(CMD_FINISH, 8'hFF);
        write_mode(1'b0);
        send_message(0, 0);
        send_message(3, 0);
        send_request(CMD_ABSORB, 8'hA5);
        write_mode(1'b0);
        send_message(2, 1);
        write_mode(1'b1);

        // random: lengths around the padding boundaries
        for (int m = 0; m < 3; m++)
        begin
            if (m == 1)
                write_mode(1'b0);
            case (m)
                0: len = $urandom_range(54, 57);
                1: len = $urandom_range(63, 65);
                default: len = $urandom_range(0, 4);
            endcase
            send_message(len, 1);
        end
        write_mode(1'b1);
        send_message($urandom_range(1, 4), 1);
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
